@@ rtl/core/tcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpc_pkg: shared types and constants of the timed cover position controller
// Codes, field widths and the request/response structs of the serial unit.
// ----------------------------------------------------------------------------
package tcpc_pkg;

  localparam int POS_W    = 7;
  localparam int TICK_W   = 18;
  localparam int TRAVEL_W = 8;
  localparam int PERIOD_W = 10;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 10;

  // serial arithmetic unit
  localparam int ARITH_W   = 28;  // dividend / product width
  localparam int DVS_W     = 12;  // divisor / multiplier width
  localparam int STEP_W    = 5;
  localparam int DIV_STEPS = 28;
  localparam int MUL_STEPS = 12;

  localparam logic [POS_W-1:0]  POS_MAX  = 7'd100;
  localparam logic [TICK_W-1:0] TICK_MAX = 18'h3FFFF;

  localparam logic [TRAVEL_W-1:0] OPEN_TRAVEL_RST  = 8'd25;
  localparam logic [TRAVEL_W-1:0] CLOSE_TRAVEL_RST = 8'd24;
  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST  = 10'd250;

  // item kinds
  localparam logic [1:0] OP_RUN  = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // motion state codes
  localparam logic [1:0] MS_OPENING = 2'd0;
  localparam logic [1:0] MS_CLOSING = 2'd1;
  localparam logic [1:0] MS_STOPPED = 2'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_OPEN_TRAVEL  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CLOSE_TRAVEL = 2'd1;
  localparam logic [CFG_AW-1:0] REG_TICK_PERIOD  = 2'd2;

  typedef struct packed {
    logic               start;
    logic               div;    // 1 divide, 0 multiply
    logic [ARITH_W-1:0] opa;    // dividend or multiplicand
    logic [DVS_W-1:0]   opb;    // divisor or multiplier
  } tcpc_arith_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;   // one-cycle pulse
    logic [ARITH_W-1:0] result;
  } tcpc_arith_rsp_t;

  function automatic logic [TRAVEL_W-1:0] nz_travel(logic [TRAVEL_W-1:0] v);
    return (v == '0) ? TRAVEL_W'(1) : v;
  endfunction

  function automatic logic [PERIOD_W-1:0] nz_period(logic [PERIOD_W-1:0] v);
    return (v == '0) ? PERIOD_W'(1) : v;
  endfunction

endpackage

@@ rtl/core/tcpc_serial_arith.sv @@
// ----------------------------------------------------------------------------
// tcpc_serial_arith: bit-serial multiply / divide unit
// Shift-add multiply (one multiplier bit per cycle) and restoring divide
// (one quotient bit per cycle), sharing one accumulator.
// ----------------------------------------------------------------------------
module tcpc_serial_arith import tcpc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  tcpc_arith_req_t req,
  output tcpc_arith_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic               is_div;
  logic [ARITH_W-1:0] acc;   // product, or dividend shifting into quotient
  logic [ARITH_W-1:0] aux;   // shifted multiplicand, or partial remainder
  logic [DVS_W-1:0]   opb;
  logic [STEP_W-1:0]  cnt;

  logic [DVS_W:0] rem_shift;
  logic [DVS_W:0] rem_diff;
  logic           rem_ge;

  always_comb begin
    rem_shift = {aux[DVS_W-1:0], acc[ARITH_W-1]};
    rem_diff  = rem_shift - {1'b0, opb};
    rem_ge    = (rem_shift >= {1'b0, opb});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.div;
        opb    <= req.opb;
        if (req.div) begin
          cnt <= STEP_W'(DIV_STEPS - 1);
          acc <= req.opa;
          aux <= '0;
        end else begin
          cnt <= STEP_W'(MUL_STEPS - 1);
          acc <= '0;
          aux <= req.opa;
        end
      end else if (busy) begin
        if (is_div) begin
          aux <= {{(ARITH_W-DVS_W){1'b0}},
                  (rem_ge ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0])};
          acc <= {acc[ARITH_W-2:0], rem_ge};
        end else begin
          if (opb[0]) acc <= acc + aux;
          aux <= {aux[ARITH_W-2:0], 1'b0};
          opb <= {1'b0, opb[DVS_W-1:1]};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

@@ rtl/core/timed_cover_position_controller_unit.sv @@
// ----------------------------------------------------------------------------
// timed_cover_position_controller_unit: dead-reckoning roller-cover control
// Sequence to m_tvalid: a tick without stop, idle stop, equal-target run or
//   unused code goes straight to the result; a halt runs a multiply then a divide;
//   a run to a new target runs a divide, a multiply and a divide.
// Throughput: one transaction at a time; the input opens again as the result is loaded,
//   so a new input is taken while a result waits; a stalled m_tready holds ST_EMIT.
// Reset (rst, sync, active high): motor off, position 0, config to defaults.
// ----------------------------------------------------------------------------
module timed_cover_position_controller_unit import tcpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,    // [6:0] set_point, [7] zero
  input  logic [1:0]        s_tuser,    // [1:0] op
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,    // [0] motor_on, [1] motor_dir,
                                        // [3:2] motion_state, [10:4] position,
                                        // [28:11] elapsed_ticks,
                                        // [29] run_finished, [31:30] zero
  // configuration writes
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,   // T*1000 / P
    ST_MUL_DIST,   // rate * delta
    ST_DIV_PCT,    // / 100
    ST_MUL_TIME,   // P * ticks
    ST_DIV_MOVE,   // / (T*10)
    ST_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [TRAVEL_W-1:0] open_travel;
  logic [TRAVEL_W-1:0] close_travel;
  logic [PERIOD_W-1:0] tick_period;

  // controller state
  logic [POS_W-1:0]  cur_position;
  logic [POS_W-1:0]  goal_position;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] stop_threshold;
  logic              closing_dir;
  logic [1:0]        run_state;
  logic              running;
  logic              finished;
  logic [POS_W-1:0]  delta;

  tcpc_arith_req_t arith_req;
  tcpc_arith_rsp_t arith_rsp;

  tcpc_serial_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  // item decode
  logic              in_fire;
  logic [POS_W-1:0]  target_sat;
  logic              new_closing;
  logic [POS_W-1:0]  new_delta;
  logic [TICK_W-1:0] tick_inc;
  logic [PERIOD_W-1:0] period_nz;
  logic [TRAVEL_W-1:0] travel_new;   // travel time for the direction being set
  logic [TRAVEL_W-1:0] travel_cur;   // travel time for the running direction
  logic [TICK_W-1:0]   rate_num;     // T * 1000, max 255000
  logic [DVS_W-1:0]    move_dvs;     // T * 10, max 2550
  logic [ARITH_W-1:0]  moved;
  logic [POS_W-1:0]    pos_halt;
  logic [TICK_W-1:0]   thr_sat;
  logic                run_go;       // run to a new target
  logic                halt_go;      // stop, or tick reaching the threshold
  logic                arith_go;     // start the serial unit next cycle
  logic                emit_load;    // result goes into the output register

  always_comb begin
    in_fire     = s_tvalid && s_tready;
    target_sat  = (s_tdata[POS_W-1:0] > POS_MAX) ? POS_MAX : s_tdata[POS_W-1:0];
    new_closing = (target_sat < cur_position);
    new_delta   = new_closing ? (cur_position - target_sat) : (target_sat - cur_position);
    tick_inc    = (tick_count == TICK_MAX) ? tick_count : (tick_count + 1'b1);
    period_nz   = nz_period(tick_period);
    travel_new  = nz_travel(new_closing ? close_travel : open_travel);
    travel_cur  = nz_travel(closing_dir ? close_travel : open_travel);
    rate_num    = TICK_W'(travel_new) * TICK_W'(1000);
    move_dvs    = DVS_W'(travel_cur) * DVS_W'(10);

    // distance covered, clamped to the travel range
    moved = arith_rsp.result;
    if (!closing_dir) begin
      if (moved >= ARITH_W'(POS_MAX - cur_position)) pos_halt = POS_MAX;
      else pos_halt = cur_position + moved[POS_W-1:0];
    end else begin
      if (moved >= ARITH_W'(cur_position)) pos_halt = '0;
      else pos_halt = cur_position - moved[POS_W-1:0];
    end

    thr_sat = (arith_rsp.result > ARITH_W'(TICK_MAX)) ? TICK_MAX
                                                      : arith_rsp.result[TICK_W-1:0];

    // serial unit kick: from an accepted item, or chaining the next step
    run_go   = (s_tuser == OP_RUN) && (target_sat != cur_position);
    halt_go  = running && ((s_tuser == OP_STOP) ||
                           ((s_tuser == OP_TICK) && (tick_inc >= stop_threshold)));
    arith_go = ((state == ST_IDLE) && in_fire && (run_go || halt_go)) ||
               (arith_rsp.done && ((state == ST_DIV_RATE) || (state == ST_MUL_DIST) ||
                                   (state == ST_MUL_TIME)));

    emit_load = (state == ST_EMIT) && (!m_tvalid || m_tready);
  end

  assign s_tready = (state == ST_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      open_travel    <= OPEN_TRAVEL_RST;
      close_travel   <= CLOSE_TRAVEL_RST;
      tick_period    <= TICK_PERIOD_RST;
      cur_position   <= '0;
      goal_position  <= '0;
      tick_count     <= '0;
      stop_threshold <= '0;
      closing_dir    <= 1'b0;
      run_state      <= MS_OPENING;
      running        <= 1'b0;
      finished       <= 1'b0;
      m_tvalid       <= 1'b0;
      arith_req.start <= 1'b0;
    end else begin
      arith_req.start <= arith_go;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_OPEN_TRAVEL:  open_travel  <= cfg_wdata[TRAVEL_W-1:0];
          REG_CLOSE_TRAVEL: close_travel <= cfg_wdata[TRAVEL_W-1:0];
          REG_TICK_PERIOD:  tick_period  <= cfg_wdata[PERIOD_W-1:0];
          default: ;
        endcase
      end

      // output register: load when free, clear once taken
      if (emit_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            finished <= 1'b0;
            case (s_tuser)
              OP_RUN: begin
                if (target_sat != cur_position) begin
                  goal_position   <= target_sat;
                  tick_count      <= '0;
                  closing_dir     <= new_closing;
                  run_state       <= new_closing ? MS_CLOSING : MS_OPENING;
                  running         <= 1'b1;
                  delta           <= new_delta;
                  arith_req.div   <= 1'b1;
                  arith_req.opa   <= ARITH_W'(rate_num);
                  arith_req.opb   <= DVS_W'(period_nz);
                  state           <= ST_DIV_RATE;
                end else begin
                  state <= ST_EMIT;
                end
              end
              OP_STOP: begin
                if (running) begin
                  arith_req.div   <= 1'b0;
                  arith_req.opa   <= ARITH_W'(tick_count);
                  arith_req.opb   <= DVS_W'(period_nz);
                  state           <= ST_MUL_TIME;
                end else begin
                  state <= ST_EMIT;
                end
              end
              OP_TICK: begin
                if (running) begin
                  tick_count <= tick_inc;
                  if (tick_inc >= stop_threshold) begin
                    arith_req.div   <= 1'b0;
                    arith_req.opa   <= ARITH_W'(tick_inc);
                    arith_req.opb   <= DVS_W'(period_nz);
                    state           <= ST_MUL_TIME;
                  end else begin
                    state <= ST_EMIT;
                  end
                end else begin
                  state <= ST_EMIT;
                end
              end
              default: state <= ST_EMIT;  // unused code: no change
            endcase
          end
        end

        ST_DIV_RATE: begin
          if (arith_rsp.done) begin
            arith_req.div   <= 1'b0;
            arith_req.opa   <= arith_rsp.result;
            arith_req.opb   <= DVS_W'(delta);
            state           <= ST_MUL_DIST;
          end
        end

        ST_MUL_DIST: begin
          if (arith_rsp.done) begin
            arith_req.div   <= 1'b1;
            arith_req.opa   <= arith_rsp.result;
            arith_req.opb   <= DVS_W'(POS_MAX);
            state           <= ST_DIV_PCT;
          end
        end

        ST_DIV_PCT: begin
          if (arith_rsp.done) begin
            stop_threshold <= thr_sat;
            state          <= ST_EMIT;
          end
        end

        ST_MUL_TIME: begin
          if (arith_rsp.done) begin
            arith_req.div   <= 1'b1;
            arith_req.opa   <= arith_rsp.result;
            arith_req.opb   <= move_dvs;
            state           <= ST_DIV_MOVE;
          end
        end

        ST_DIV_MOVE: begin
          if (arith_rsp.done) begin
            cur_position <= pos_halt;
            running      <= 1'b0;
            run_state    <= MS_STOPPED;
            finished     <= 1'b1;
            state        <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          // hold until the output register is free
          if (emit_load) begin
            m_tdata  <= {2'b00, finished, tick_count, cur_position,
                         run_state, closing_dir, running};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the serial unit is never mid-operation while a new transaction is taken
  a_idle_arith_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !arith_rsp.busy)
    else $error("arith unit busy while accepting input");

  // a transaction closes the input until its result is loaded
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("input accepted twice without emitting a result");

  // a finish pulse always reports the motor off and the stopped state
  a_finish_stopped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[29]) |-> (!m_tdata[0] && m_tdata[3:2] == MS_STOPPED))
    else $error("run_finished with motor still on");

  // the position estimate stays within the travel range
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cur_position <= POS_MAX)
    else $error("position out of range");

  // a stored goal never exceeds the travel range
  a_goal_range: assert property (@(posedge clk) disable iff (rst)
    $past(in_fire) |-> goal_position <= POS_MAX)
    else $error("goal position out of range");

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the timed cover position controller
// Streams run, stop and tick transactions into the unit and checks every
// result field against a cycle-free prediction of motor, direction, position
// and tick count. Several travel-time and tick-period settings are used,
// the extremes and zero among them. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tcpc_pkg::*;

  // op code three has no function; the unit ignores it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 220;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [1:0]       op;
    logic [POS_W-1:0] target;
    bit               drain_first;  // hold until all results are back
  } cover_item_t;

  typedef struct {
    logic              motor_on;
    logic              motor_dir;
    logic [1:0]        motion;
    logic [POS_W-1:0]  position;
    logic [TICK_W-1:0] elapsed;
    logic              finished;
  } cover_status_t;

  // registers plus controller state
  typedef struct {
    logic [TRAVEL_W-1:0] open_s;
    logic [TRAVEL_W-1:0] close_s;
    logic [PERIOD_W-1:0] period;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    goal;
    logic [TICK_W-1:0]   ticks;
    logic [TICK_W-1:0]   thresh;
    logic                closing;
    logic                running;
    logic [1:0]          mstate;
  } cover_state_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;     // [6:0] set_point, [7] zero
  logic [1:0]          s_tuser = '0;     // [1:0] op
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;          // [0] motor_on, [1] motor_dir,
                                         // [3:2] motion_state, [10:4] position,
                                         // [28:11] elapsed_ticks,
                                         // [29] run_finished, [31:30] zero
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  timed_cover_position_controller_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  cover_item_t   pending_items[$];      // planned, not yet sent
  cover_status_t expected_status[$];    // one per accepted transaction
  cover_state_t  cover_now;             // state as of the last accepted item
  cover_state_t  cover_plan;            // state after the last planned item

  int  acc_count = 0;        // transactions accepted on the input side
  int  resp_count = 0;       // results accepted on the output side
  int  error_count = 0;
  int  cycle_count = 0;
  int  planned_active = 0;   // planned items that are not ignored by the unit
  int  settings_used = 1;
  int  halts_at_threshold = 0;
  int  halts_by_stop = 0;
  bit  hold_next = 1'b0;
  bit  calm_stretch = 1'b0;  // no idling on either side while set

  function automatic int unsigned floor_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // travel time of the current direction, zero read as one
  function automatic int unsigned eff_travel(cover_state_t s);
    return floor_one(32'(s.closing ? s.close_s : s.open_s));
  endfunction

  // position after the motor stops: distance from ticks times period
  function automatic logic [POS_W-1:0] settled_pos(cover_state_t s);
    longint unsigned per, trv, cnt, moved, p;
    per = 64'(floor_one(32'(s.period)));
    trv = 64'(eff_travel(s));
    cnt = 64'(s.ticks);
    moved = (per * cnt) / (trv * 10);
    if (!s.closing) begin
      p = s.pos + moved;
      if (p > POS_MAX) p = POS_MAX;
    end else begin
      p = (moved >= s.pos) ? 0 : s.pos - moved;
    end
    return p[POS_W-1:0];
  endfunction

  function automatic cover_state_t cover_reset_state();
    cover_state_t s;
    s.open_s  = OPEN_TRAVEL_RST;
    s.close_s = CLOSE_TRAVEL_RST;
    s.period  = TICK_PERIOD_RST;
    s.pos     = '0;
    s.goal    = '0;
    s.ticks   = '0;
    s.thresh  = '0;
    s.closing = 1'b0;
    s.running = 1'b0;
    s.mstate  = MS_OPENING;   // cleared state reads as opening
    return s;
  endfunction

  task automatic advance_cover(inout cover_state_t s, input cover_item_t it,
                               output cover_status_t r);
    logic [POS_W-1:0] goal;
    longint unsigned  delta, trv, th;
    bit               halt;
    halt = 1'b0;
    goal = (it.target > POS_MAX) ? POS_MAX : it.target;
    case (it.op)
      OP_RUN: begin
        if (goal != s.pos) begin
          s.goal    = goal;
          s.ticks   = '0;
          s.closing = (goal < s.pos);
          s.mstate  = s.closing ? MS_CLOSING : MS_OPENING;
          delta     = s.closing ? 64'(s.pos - goal) : 64'(goal - s.pos);
          trv       = 64'(eff_travel(s));
          th        = (trv * 1000) / 64'(floor_one(32'(s.period)));
          th        = (th * delta) / 100;
          if (th > TICK_MAX) th = TICK_MAX;
          s.thresh  = th[TICK_W-1:0];
          s.running = 1'b1;
        end
      end
      OP_STOP: halt = s.running;
      OP_TICK: begin
        if (s.running) begin
          if (s.ticks < TICK_MAX) s.ticks = s.ticks + 1'b1;
          halt = (s.ticks >= s.thresh);
        end
      end
      default: ;
    endcase
    if (halt) begin
      s.pos     = settled_pos(s);
      s.running = 1'b0;
      s.mstate  = MS_STOPPED;
    end
    r.motor_on  = s.running;
    r.motor_dir = s.closing;
    r.motion    = s.mstate;
    r.position  = s.pos;
    r.elapsed   = s.ticks;
    r.finished  = halt;
  endtask

  // --------------------------------------------------------------------------
  // Driver: sends planned items; predicts each one at its acceptance
  // --------------------------------------------------------------------------
  cover_item_t tx_item;

  always @(posedge clk) begin : driver
    cover_status_t st;
    bit            blocked;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_cover(cover_now, tx_item, st);
        expected_status.push_back(st);
        acc_count++;
        if (st.finished) begin
          if (tx_item.op == OP_TICK) halts_at_threshold++;
          else halts_by_stop++;
        end
      end
      calm_stretch <= (acc_count >= 500) && (acc_count < 800);
      if (!s_tvalid || s_tready) begin
        // a marked item waits until every result so far is back
        blocked = (pending_items.size() == 0) ||
                  (pending_items[0].drain_first && acc_count != resp_count);
        if (!blocked && (calm_stretch || $urandom_range(99) >= 12)) begin
          tx_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, tx_item.target};
          s_tuser  <= tx_item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure, field-by-field compare
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH cycle %0d result %0d: %s", cycle_count, resp_count, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    cover_status_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        resp_count <= resp_count + 1;
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
        end else begin
          want = expected_status.pop_front();
          check_field("motor_on",      32'(m_tdata[0]),     32'(want.motor_on));
          check_field("motor_dir",     32'(m_tdata[1]),     32'(want.motor_dir));
          check_field("motion_state",  32'(m_tdata[3:2]),   32'(want.motion));
          check_field("position",      32'(m_tdata[10:4]),  32'(want.position));
          check_field("elapsed_ticks", 32'(m_tdata[28:11]), 32'(want.elapsed));
          check_field("run_finished",  32'(m_tdata[29]),    32'(want.finished));
        end
      end
      m_tready <= calm_stretch || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d sent, %0d results back", acc_count, resp_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  // queue one item and track the state it leads to
  task automatic queue_item(input logic [1:0] op, input int unsigned target);
    cover_item_t   it;
    cover_status_t unused;
    int unsigned   goal;
    it.op          = op;
    it.target      = target[POS_W-1:0];
    it.drain_first = hold_next;
    hold_next      = 1'b0;
    goal = (target > POS_MAX) ? POS_MAX : target;
    if ((op == OP_RUN && goal != cover_plan.pos) ||
        ((op == OP_STOP || op == OP_TICK) && cover_plan.running))
      planned_active++;
    advance_cover(cover_plan, it, unused);
    pending_items.push_back(it);
  endtask

  // wait until nothing is in flight; sampled away from the active edge
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_status.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CFG_DW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_OPEN_TRAVEL: begin
        cover_now.open_s  = val[TRAVEL_W-1:0];
        cover_plan.open_s = val[TRAVEL_W-1:0];
      end
      REG_CLOSE_TRAVEL: begin
        cover_now.close_s  = val[TRAVEL_W-1:0];
        cover_plan.close_s = val[TRAVEL_W-1:0];
      end
      REG_TICK_PERIOD: begin
        cover_now.period  = val[PERIOD_W-1:0];
        cover_plan.period = val[PERIOD_W-1:0];
      end
      default: ;
    endcase
  endtask

  // mostly complete runs: a run item, ticks up to the threshold, past it or short
  // of it, then mostly a stop if cut short; the rest is unstructured noise
  task automatic plan_random_phase(input int budget);
    int unsigned base, slowest, per_full, span, delta, goal, full, n, choice;
    base = planned_active;
    while (planned_active - base < budget) begin
      if ($urandom_range(99) == 0) hold_next = 1'b1;
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(9) == 0) begin
          goal = $urandom_range(127);
        end else begin
          // keep most runs within a few hundred ticks
          slowest  = floor_one(32'((cover_plan.open_s > cover_plan.close_s) ?
                                   cover_plan.open_s : cover_plan.close_s));
          per_full = slowest * 1000 / floor_one(32'(cover_plan.period));
          span     = (per_full <= 400) ? 100 : 40000 / per_full;
          if (span == 0) span = 1;
          delta = $urandom_range(span, 1);
          if (($urandom_range(1) && cover_plan.pos + delta <= 100) ||
              cover_plan.pos < delta)
            goal = (cover_plan.pos + delta > 100) ? 100 : cover_plan.pos + delta;
          else
            goal = cover_plan.pos - delta;
        end
        queue_item(OP_RUN, goal);
        if (cover_plan.running) begin
          full   = (cover_plan.thresh == 0) ? 1 : cover_plan.thresh;
          choice = $urandom_range(9);
          if (full <= 500 && choice < 7)
            n = full;
          else if (full <= 500 && choice == 7)
            n = full + $urandom_range(3, 1);   // extra ticks land while idle
          else
            n = $urandom_range((full > 30) ? 30 : full - 1, 0);
          repeat (n) queue_item(OP_TICK, $urandom_range(127));
          // choice nine leaves the motor on for whatever comes next
          if (n < full && choice != 9) queue_item(OP_STOP, $urandom_range(127));
        end
      end else begin
        queue_item(2'($urandom_range(3)), $urandom_range(127));
      end
    end
  endtask

  task automatic run_phase(input int unsigned open_s, input int unsigned close_s,
                           input int unsigned period);
    wait_idle();
    write_reg(REG_OPEN_TRAVEL, open_s);
    write_reg(REG_CLOSE_TRAVEL, close_s);
    write_reg(REG_TICK_PERIOD, period);
    settings_used++;
    @(negedge clk);
    plan_random_phase(PHASE_ITEMS);
  endtask

  initial begin
    cover_now  = cover_reset_state();
    cover_plan = cover_reset_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset register values
    queue_item(OP_TICK, 127);       // tick while idle
    queue_item(OP_STOP, 0);         // stop while idle
    queue_item(OP_UNUSED, 127);     // unused code
    queue_item(OP_RUN, 0);          // target equals position
    queue_item(OP_RUN, 3);          // opening, three ticks
    repeat (3) queue_item(OP_TICK, 0);
    queue_item(OP_TICK, 0);         // idle again
    queue_item(OP_RUN, 1);          // closing run, one tick
    queue_item(OP_TICK, 0);
    queue_item(OP_RUN, 127);        // saturates to fully open
    queue_item(OP_RUN, 50);         // restart while running
    queue_item(OP_TICK, 0);
    hold_next = 1'b1;               // sender waits for every result first
    queue_item(OP_STOP, 0);         // stop mid-run
    queue_item(OP_STOP, 0);

    // directed: tiny threshold, so a partial run stops at the first tick
    wait_idle();
    write_reg(REG_OPEN_TRAVEL, 1);
    write_reg(REG_CLOSE_TRAVEL, 1);
    write_reg(REG_TICK_PERIOD, 1000);
    settings_used++;
    @(negedge clk);
    queue_item(OP_RUN, 40);         // zero threshold
    queue_item(OP_TICK, 0);         // overshoots, clamped at fully open
    queue_item(OP_RUN, 0);
    queue_item(OP_RUN, 0);          // same target again while running
    queue_item(OP_TICK, 0);         // clamped at closed
    queue_item(OP_RUN, 0);

    // random phases: reset values, extremes, zero registers, mixed, random
    run_phase(25, 24, 250);
    run_phase(1, 1, 1000);
    run_phase(255, 255, 1);
    run_phase(0, 0, 0);
    run_phase(200, 7, 1023);
    run_phase($urandom_range(255), $urandom_range(255), $urandom_range(1023));

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d transactions over %0d register settings (zero and extreme values",
             acc_count, settings_used);
    $display("  included); %0d runs ended at threshold, %0d by stop, %0d results compared",
             halts_at_threshold, halts_by_stop, resp_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
